// ===== rtl/core/lbas_pkg.sv =====
// package for the led bar animation sequencer: codes, state type and tick functions
package lbas_pkg;

	localparam int BAR_LEDS = 5;
	localparam int LED_OUT_W = 5;
	localparam int MASK_EXT_W = (BAR_LEDS > LED_OUT_W) ? BAR_LEDS : LED_OUT_W;
	localparam int POS_W = $clog2(BAR_LEDS + 2) + 1;
	localparam int PAIR_HALF = BAR_LEDS / 2;
	localparam int PAIR_W = $clog2(PAIR_HALF + 2);
	localparam int COLOR_W = 24;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFA500;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [PAIR_W-1:0] pair_t;
	typedef logic [BAR_LEDS-1:0] seg_t;

	localparam pos_t POS_ZERO = pos_t'(0);
	localparam pos_t POS_ONE = pos_t'(1);
	localparam pos_t POS_MAX = pos_t'(BAR_LEDS);
	localparam pair_t PAIR_ONE = pair_t'(1);
	localparam pair_t PAIR_MAX = pair_t'(PAIR_HALF);

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_BOOT = 2'd1,
		MODE_SHUT = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ANIM_IDLE = 3'd0,
		ANIM_DOT = 3'd1,
		ANIM_PAIR = 3'd2,
		ANIM_BOOT = 3'd3,
		ANIM_SHUT = 3'd4
	} anim_t;

	typedef struct packed {
		pos_t pos;
		logic desc;
		pair_t pair;
		logic phase;
		logic fill_done;
		seg_t mask;
	} st_t;

	localparam st_t STATE_RESET = '{
		pos: POS_ZERO, desc: 1'b0, pair: '0, phase: 1'b0, fill_done: 1'b0, mask: '0
	};

	// segments i with lo <= i < hi
	function automatic seg_t range_mask(pos_t lo, pos_t hi);
		seg_t m;
		pos_t pi;
		m = '0;
		for (int i = 0; i < BAR_LEDS; i++) begin
			pi = pos_t'(i);
			m[i] = (pi >= lo) && (pi < hi);
		end
		return m;
	endfunction

	function automatic st_t idle_tick(st_t s);
		st_t r;
		pos_t p;
		r = s;
		r.mask = range_mask(POS_ZERO, s.pos);
		if (!s.desc) begin
			p = s.pos + POS_ONE;
			if (p > POS_MAX) begin
				r.pos = POS_MAX;
				r.desc = 1'b1;
			end else begin
				r.pos = p;
			end
		end else begin
			p = (s.pos > POS_ZERO) ? s.pos - POS_ONE : s.pos;
			r.pos = p;
			if (p == POS_ZERO)
				r.desc = 1'b0;
		end
		return r;
	endfunction

	function automatic st_t dot_tick(st_t s);
		st_t r;
		pos_t p;
		r = s;
		r.mask = range_mask(s.pos - POS_ONE, s.pos);
		if (!s.desc) begin
			p = s.pos + POS_ONE;
			if (p >= POS_MAX) begin
				r.pos = POS_MAX;
				r.desc = 1'b1;
			end else begin
				r.pos = p;
			end
		end else begin
			p = s.pos - POS_ONE;
			if (p <= POS_ONE) begin
				r.pos = POS_ONE;
				r.desc = 1'b0;
			end else begin
				r.pos = p;
			end
		end
		return r;
	endfunction

	function automatic st_t pair_tick(st_t s);
		st_t r;
		pair_t p;
		r = s;
		for (int i = 0; i < BAR_LEDS; i++)
			r.mask[i] = (i == int'(s.pair)) || (i == BAR_LEDS - 1 - int'(s.pair));
		if (!s.desc) begin
			p = s.pair + PAIR_ONE;
			if (p >= PAIR_MAX) begin
				r.pair = PAIR_MAX;
				r.desc = 1'b1;
			end else begin
				r.pair = p;
			end
		end else begin
			p = (s.pair != '0) ? s.pair - PAIR_ONE : s.pair;
			r.pair = p;
			if (p == '0)
				r.desc = 1'b0;
		end
		return r;
	endfunction

	function automatic st_t boot_tick(st_t s);
		st_t r;
		pos_t p;
		r = s;
		p = (s.pos >= POS_ZERO) ? s.pos - POS_ONE : s.pos;
		if (s.phase) begin
			r = idle_tick(s);
		end else if (!s.fill_done) begin
			// fill from the top
			r.mask = range_mask(s.pos, POS_MAX);
			if (p < POS_ZERO) begin
				r.fill_done = 1'b1;
				r.pos = POS_MAX;
			end else begin
				r.pos = p;
			end
		end else begin
			// drain, then hand over to idle fill
			r.mask = range_mask(POS_ZERO, s.pos);
			if (p < POS_ZERO) begin
				r.phase = 1'b1;
				r.pos = POS_ZERO;
			end else begin
				r.pos = p;
			end
		end
		return r;
	endfunction

	function automatic st_t shut_tick(st_t s);
		st_t r;
		pos_t p;
		r = s;
		p = (s.pos >= POS_ZERO) ? s.pos - POS_ONE : s.pos;
		if (!s.phase) begin
			r.mask = '0;
		end else begin
			r.mask = range_mask(POS_ZERO, s.pos);
			if (p < POS_ZERO) begin
				r.phase = 1'b0;
				r.pos = POS_ZERO;
			end else begin
				r.pos = p;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/lbas_step.sv =====
// next-state logic for one request of the led bar sequencer
module lbas_step import lbas_pkg::*; (
	input  st_t        cur,
	input  logic [1:0] mode,
	input  logic [2:0] animation,
	output st_t        nxt
);

	st_t pre;

	always_comb begin
		pre = cur;
		nxt = cur;
		unique case (mode_t'(mode))
			MODE_BOOT: begin
				pre.pos = POS_MAX;
				pre.phase = 1'b0;
				pre.fill_done = 1'b0;
				nxt = boot_tick(pre);
			end
			MODE_SHUT: begin
				pre.pos = POS_MAX;
				pre.phase = 1'b1;
				nxt = shut_tick(pre);
			end
			MODE_CLEAR: begin
				nxt.pos = POS_ZERO;
			end
			MODE_TICK: begin
				unique case (animation)
					ANIM_IDLE: nxt = idle_tick(cur);
					ANIM_DOT:  nxt = dot_tick(cur);
					ANIM_PAIR: nxt = pair_tick(cur);
					ANIM_BOOT: nxt = boot_tick(cur);
					ANIM_SHUT: nxt = shut_tick(cur);
					default:   nxt = cur;
				endcase
			end
			default: nxt = cur;
		endcase
	end

endmodule

// ===== rtl/core/led_bar_animation_sequencer.sv =====
// led bar animation sequencer: request register, state update and result register
//
// Animates a short LED bar (BAR_LEDS segments, low five shown on led_mask) in
// five patterns: bouncing fill, single dot, meeting pair, boot fill/drain and
// shutdown drain. Each request is a tick for one animation or a command (start
// boot, start shutdown, clear position) and returns exactly one result with
// the lit-segment mask, the bar colour and the boot/shutdown flags. Requests
// are taken one per clock cycle without gaps while the result side does not
// stall; a result passes the request register, then the result register. The
// rate rests on the loop through the animation state register, which each
// request reads and updates before the next one is worked on. A stalled result
// holds in the result register while the request register still takes one more
// request. The user writes bar_color via cfg_we and cfg_wdata only while no
// request is in flight, unchecked by the block. It resets to orange (FFA500).
module led_bar_animation_sequencer import lbas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [2:0]         animation,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         led_mask,
	output logic [COLOR_W-1:0] on_color,
	output logic               boot_active,
	output logic               fill_finished
);

	// configuration
	logic [COLOR_W-1:0] bar_color_q;

	// request register
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [2:0] anim_s1;

	// animation state
	st_t state_q;
	st_t state_nxt;

	// result register
	logic               out_valid_q;
	logic [4:0]         led_mask_q;
	logic [COLOR_W-1:0] on_color_q;
	logic               boot_active_q;
	logic               fill_finished_q;

	logic              advance;
	logic [MASK_EXT_W-1:0] mask_ext;

	// request moves on when the result register is free or being emptied
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_color_q <= COLOR_RESET;
		end else if (cfg_we) begin
			bar_color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			anim_s1 <= animation;
		end
	end

	lbas_step u_step (
		.cur       (state_q),
		.mode      (mode_s1),
		.animation (anim_s1),
		.nxt       (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// a wider bar shows only its low segments
	assign mask_ext = MASK_EXT_W'(state_nxt.mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_mask_q <= mask_ext[4:0];
			on_color_q <= bar_color_q;
			boot_active_q <= state_nxt.phase;
			fill_finished_q <= state_nxt.fill_done;
		end
	end

	assign out_valid = out_valid_q;
	assign led_mask = led_mask_q;
	assign on_color = on_color_q;
	assign boot_active = boot_active_q;
	assign fill_finished = fill_finished_q;

	// position tracker stays inside its range
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pos >= POS_ZERO) && (state_q.pos <= POS_MAX))
		else $error("position tracker out of range");

	// pair tracker never passes the middle
	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pair <= PAIR_MAX)
		else $error("pair tracker out of range");

	// a free result side never blocks the request side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q || out_ready) |-> in_ready)
		else $error("request side stalled with result side free");

	// a new result only comes from a held request
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q || out_ready) ##1 out_valid_q |-> $past(valid_s1))
		else $error("result without request");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the led bar animation sequencer
module testbench;
	import lbas_pkg::*;

	// animation codes past the last defined one, ignored by the block
	localparam logic [2:0] ANIM_SPARE_LO = 3'd5;
	localparam logic [2:0] ANIM_SPARE_HI = 3'd7;

	localparam int IDLE_PCT = 21;
	localparam int RANDOM_PER_PHASE = 220;
	localparam int COLOR_PHASES = 4;
	// window of requests and results with no idling on either side
	localparam int CALM_LO = 450;
	localparam int CALM_HI = 600;
	// the one long receiver hold-off starts after this many results
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 64;

	// one frame as seen on the result port
	typedef struct packed {
		logic [4:0] mask;
		logic [COLOR_W-1:0] color;
		logic active;
		logic finished;
	} bar_frame_t;

	// directed request, with a hand-typed frame where typed is set
	typedef struct packed {
		mode_t m;
		logic [2:0] a;
		logic typed;
		logic [4:0] mask;
		logic active;
		logic finished;
	} script_row_t;

	// animation state kept by the testbench predictor
	typedef struct {
		int pos;
		bit desc;
		int pair;
		bit phase;
		bit fdone;
		logic [BAR_LEDS-1:0] segs;
	} bar_state_t;

	localparam int DIRECTED_ROWS = 27;

	// reset frame, unknown codes, shutdown without a phase, clear, a full
	// shutdown drain and a full boot fill and drain running on into idle fill
	localparam script_row_t SCRIPT [DIRECTED_ROWS] = '{
		'{MODE_TICK,  ANIM_IDLE,     1'b1, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SPARE_HI, 1'b1, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_DOT,      1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_PAIR,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SHUT,     1'b1, 5'h00, 1'b0, 1'b0},
		'{MODE_CLEAR, ANIM_SPARE_HI, 1'b1, 5'h00, 1'b0, 1'b0},
		'{MODE_SHUT,  ANIM_SPARE_HI, 1'b1, 5'h1F, 1'b1, 1'b0},
		'{MODE_TICK,  ANIM_SHUT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SHUT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SHUT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SHUT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SHUT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SHUT,     1'b1, 5'h00, 1'b0, 1'b0},
		'{MODE_BOOT,  ANIM_SPARE_HI, 1'b1, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_BOOT,     1'b0, 5'h00, 1'b0, 1'b0},
		'{MODE_TICK,  ANIM_SPARE_LO, 1'b0, 5'h00, 1'b0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [COLOR_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_TICK;
	logic [2:0] animation = ANIM_IDLE;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] led_mask;
	logic [COLOR_W-1:0] on_color;
	logic boot_active;
	logic fill_finished;

	// predictor state and the frames still owed by the block
	bar_state_t bar;
	logic [COLOR_W-1:0] color_reg;
	bar_frame_t frames_due[$];

	int requests_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int boot_starts = 0;
	int shut_starts = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	led_bar_animation_sequencer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.animation(animation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_mask(led_mask),
		.on_color(on_color),
		.boot_active(boot_active),
		.fill_finished(fill_finished)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// segments lo..hi-1 lit, clipped to the bar
	function automatic logic [BAR_LEDS-1:0] lit_span(int lo, int hi);
		logic [BAR_LEDS-1:0] m;
		m = '0;
		for (int i = 0; i < BAR_LEDS; i++)
			if (i >= lo && i < hi)
				m[i] = 1'b1;
		return m;
	endfunction

	// bouncing fill: show the bar below pos, then move pos one step
	function automatic void step_fill();
		bar.segs = (bar.pos <= 0) ? '0 : lit_span(0, bar.pos);
		if (!bar.desc) begin
			bar.pos++;
			if (bar.pos > BAR_LEDS) begin
				bar.pos = BAR_LEDS;
				bar.desc = 1'b1;
			end
		end else begin
			if (bar.pos > 0)
				bar.pos--;
			if (bar.pos == 0)
				bar.desc = 1'b0;
		end
	endfunction

	// single dot at pos-1, bouncing between segment 0 and the top
	function automatic void step_dot();
		bar.segs = lit_span(bar.pos - 1, bar.pos);
		if (!bar.desc) begin
			bar.pos++;
			if (bar.pos >= BAR_LEDS) begin
				bar.pos = BAR_LEDS;
				bar.desc = 1'b1;
			end
		end else begin
			bar.pos--;
			if (bar.pos <= 1) begin
				bar.pos = 1;
				bar.desc = 1'b0;
			end
		end
	endfunction

	// two dots mirrored about the middle
	function automatic void step_pair();
		bar.segs = lit_span(bar.pair, bar.pair + 1) |
			lit_span(BAR_LEDS - 1 - bar.pair, BAR_LEDS - bar.pair);
		if (!bar.desc) begin
			bar.pair++;
			if (bar.pair >= BAR_LEDS / 2) begin
				bar.pair = BAR_LEDS / 2;
				bar.desc = 1'b1;
			end
		end else begin
			if (bar.pair > 0)
				bar.pair--;
			if (bar.pair <= 0)
				bar.desc = 1'b0;
		end
	endfunction

	// drain from the top, true once pos runs below zero
	function automatic bit step_drain();
		bar.segs = lit_span(0, bar.pos);
		if (bar.pos >= 0)
			bar.pos--;
		return bar.pos < 0;
	endfunction

	function automatic void step_boot();
		if (bar.phase) begin
			// boot finished, carries on as idle fill
			step_fill();
		end else if (!bar.fdone) begin
			bar.segs = lit_span(bar.pos, BAR_LEDS);
			if (bar.pos >= 0)
				bar.pos--;
			if (bar.pos < 0) begin
				bar.fdone = 1'b1;
				bar.pos = BAR_LEDS;
			end
		end else if (step_drain()) begin
			bar.phase = 1'b1;
			bar.pos = 0;
		end
	endfunction

	function automatic void step_shutdown();
		if (!bar.phase) begin
			// shutdown over or never started: blank bar
			bar.segs = '0;
		end else if (step_drain()) begin
			bar.phase = 1'b0;
			bar.pos = 0;
		end
	endfunction

	// apply one request to the predictor, return the frame it shows
	function automatic bar_frame_t advance_bar(mode_t m, logic [2:0] a);
		bar_frame_t f;
		case (m)
			MODE_BOOT: begin
				bar.pos = BAR_LEDS;
				bar.phase = 1'b0;
				bar.fdone = 1'b0;
				step_boot();
			end
			MODE_SHUT: begin
				bar.pos = BAR_LEDS;
				bar.phase = 1'b1;
				step_shutdown();
			end
			MODE_CLEAR: bar.pos = 0;
			default: begin
				case (a)
					ANIM_IDLE: step_fill();
					ANIM_DOT: step_dot();
					ANIM_PAIR: step_pair();
					ANIM_BOOT: step_boot();
					ANIM_SHUT: step_shutdown();
					default: ;
				endcase
			end
		endcase
		f.mask = 5'(bar.segs);
		f.color = color_reg;
		f.active = bar.phase;
		f.finished = bar.fdone;
		return f;
	endfunction

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------

	// offer one request at a falling edge and hold it until accepted;
	// a typed frame replaces the predicted one as the expectation
	task automatic send_request(mode_t m, logic [2:0] a, bit typed = 1'b0,
			logic [4:0] t_mask = '0, bit t_active = 1'b0, bit t_finished = 1'b0);
		bar_frame_t f;
		bit calm;
		@(negedge clk);
		calm = (requests_sent >= CALM_LO) && (requests_sent < CALM_HI);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		animation <= a;
		do
			@(posedge clk);
		while (!in_ready);
		f = advance_bar(m, a);
		if (typed) begin
			f.mask = t_mask;
			f.active = t_active;
			f.finished = t_finished;
		end
		frames_due.push_back(f);
		requests_sent++;
		if (m == MODE_BOOT)
			boot_starts++;
		if (m == MODE_SHUT)
			shut_starts++;
	endtask

	// drop valid and wait for every owed frame
	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(negedge clk);
	endtask

	// new bar colour, only with nothing in flight
	task automatic write_color(logic [COLOR_W-1:0] value);
		drain_requests();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		color_reg = value;
	endtask

	// one random stretch of requests, mostly whole boot and shutdown runs so
	// that the later phases get reached, with some noise mixed in
	task automatic drive_episode();
		int pick;
		int n;
		logic [2:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_request(MODE_BOOT, 3'($urandom_range(0, 7)));
			n = $urandom_range(4, 18);
			repeat (n) begin
				if ($urandom_range(0, 11) == 0)
					send_request(mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
				else
					send_request(MODE_TICK, ANIM_BOOT);
			end
		end else if (pick < 50) begin
			send_request(MODE_SHUT, 3'($urandom_range(0, 7)));
			n = $urandom_range(2, 8);
			repeat (n)
				send_request(MODE_TICK, ANIM_SHUT);
		end else if (pick < 80) begin
			a = 3'($urandom_range(ANIM_IDLE, ANIM_PAIR));
			n = $urandom_range(1, 14);
			repeat (n)
				send_request(MODE_TICK, a);
		end else if (pick < 88) begin
			send_request(MODE_CLEAR, 3'($urandom_range(0, 7)));
		end else begin
			n = $urandom_range(1, 3);
			repeat (n)
				send_request(mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
		end
	endtask

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	// random stalls, a calm window, and one long hold-off so the block fills
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			out_ready <= 1'b0;
			hold_left = HOLD_CYCLES - 1;
			hold_done = 1'b1;
		end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
	endtask

	// compare each accepted frame with the oldest one owed
	always @(posedge clk) begin
		bar_frame_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (frames_due.size() == 0) begin
				flag_mismatch("result with none owed, led_mask", 0, led_mask);
			end else begin
				want = frames_due.pop_front();
				if (led_mask !== want.mask)
					flag_mismatch("led_mask", want.mask, led_mask);
				if (on_color !== want.color)
					flag_mismatch("on_color", want.color, on_color);
				if (boot_active !== want.active)
					flag_mismatch("boot_active", want.active, boot_active);
				if (fill_finished !== want.finished)
					flag_mismatch("fill_finished", want.finished, fill_finished);
			end
		end
	end

	// ---------------------------------------------------------------
	// run
	// ---------------------------------------------------------------

	initial begin
		logic [COLOR_W-1:0] c;
		bar = '{pos: 0, desc: 1'b0, pair: 0, phase: 1'b0, fdone: 1'b0, segs: '0};
		color_reg = COLOR_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset colour
		foreach (SCRIPT[i])
			send_request(SCRIPT[i].m, SCRIPT[i].a, SCRIPT[i].typed, SCRIPT[i].mask,
				SCRIPT[i].active, SCRIPT[i].finished);

		// random part, one colour per phase: black, white, then random
		for (int k = 0; k < COLOR_PHASES; k++) begin
			case (k)
				0: c = '0;
				1: c = '1;
				default: c = COLOR_W'($urandom);
			endcase
			write_color(c);
			while (requests_sent < DIRECTED_ROWS + (k + 1) * RANDOM_PER_PHASE)
				drive_episode();
		end

		drain_requests();
		// wait on to catch any stray result
		repeat (8) @(posedge clk);
		$display("covered %0d requests (%0d directed), %0d results, %0d mismatches",
			requests_sent, DIRECTED_ROWS, results_seen, mismatches);
		$display("boot starts %0d, shutdown starts %0d, %0d colour settings",
			boot_starts, shut_starts, COLOR_PHASES + 1);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
